### hw/rtl/rcf_pkg.sv
package rcf_pkg;

  localparam int SCREEN_W_DEF   = 320;
  localparam int SCREEN_H_DEF   = 240;
  localparam int ROW_STRIDE_DEF = 512;

  localparam int FUNC_W  = 2;
  localparam int POS_W   = 11;
  localparam int DIM_W   = 10;
  localparam int RAD_W   = 9;
  localparam int COLOR_W = 16;
  localparam int COUNT_W = 17;

  // Clipping arithmetic, multiplier operands and squared distances.
  localparam int COORD_W = 13;
  localparam int MUL_W   = 12;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int SQ_W    = 23;

  localparam logic [FUNC_W-1:0] FUNC_RECT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CIRCLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_M_ROW,
    S_M_RR,
    S_M_DX,
    S_M_DY,
    S_DRAW,
    S_FIN,
    S_RD_MUL,
    S_RD_ADDR,
    S_RD_DATA
  } state_t;

endpackage

### hw/rtl/rcf_mul.sv
module rcf_mul (
  input  logic                                clk,
  input  logic signed [rcf_pkg::MUL_W-1:0]    a_i,
  input  logic signed [rcf_pkg::MUL_W-1:0]    b_i,
  output logic signed [rcf_pkg::PROD_W-1:0]   p_r
);

  always_ff @(posedge clk) begin
    p_r <= rcf_pkg::PROD_W'(a_i) * rcf_pkg::PROD_W'(b_i);
  end

endmodule

### hw/rtl/rcf_mem.sv
module rcf_mem #(
  parameter int DEPTH = rcf_pkg::SCREEN_H_DEF * rcf_pkg::ROW_STRIDE_DEF + rcf_pkg::SCREEN_W_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic [rcf_pkg::COLOR_W-1:0]   wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic [rcf_pkg::COLOR_W-1:0]   rdata_r
);

  logic [rcf_pkg::COLOR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk) begin
    if (re_i) begin
      rdata_r <= mem[raddr_i];
    end
  end

endmodule

### hw/rtl/rcf_seq.sv
module rcf_seq #(
  parameter int SCREEN_W    = rcf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H    = rcf_pkg::SCREEN_H_DEF,
  parameter int ROW_STRIDE  = rcf_pkg::ROW_STRIDE_DEF,
  parameter int STORE_DEPTH = SCREEN_H * ROW_STRIDE + SCREEN_W,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rcf_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [rcf_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [rcf_pkg::POS_W-1:0]    in_pos_y,
  input  logic [rcf_pkg::DIM_W-1:0]           in_width_px,
  input  logic [rcf_pkg::DIM_W-1:0]           in_height_px,
  input  logic [rcf_pkg::RAD_W-1:0]           in_radius,
  input  logic [rcf_pkg::COLOR_W-1:0]         in_pixel_color,
  output logic                                out_valid,
  output logic [rcf_pkg::COLOR_W-1:0]         out_read_value,
  output logic [rcf_pkg::COUNT_W-1:0]         out_pixel_count,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_waddr,
  output logic [rcf_pkg::COLOR_W-1:0]         mem_wdata,
  output logic                                mem_re,
  output logic [AW-1:0]                       mem_raddr,
  input  logic [rcf_pkg::COLOR_W-1:0]         mem_rdata
);

  localparam int CW = rcf_pkg::COORD_W;
  localparam int MW = rcf_pkg::MUL_W;
  localparam int QW = rcf_pkg::SQ_W;
  localparam int XW = (SCREEN_W > 1) ? $clog2(SCREEN_W) : 1;
  localparam int YW = (SCREEN_H > 1) ? $clog2(SCREEN_H) : 1;
  localparam logic signed [CW-1:0] W_C = CW'(SCREEN_W);
  localparam logic signed [CW-1:0] H_C = CW'(SCREEN_H);
  localparam logic signed [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [QW-1:0] ONE_Q = QW'(1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] STRIDE_A = AW'(ROW_STRIDE);
  localparam logic signed [MW-1:0] STRIDE_M = MW'(ROW_STRIDE);

  rcf_pkg::state_t state_r, state_nxt;

  logic [rcf_pkg::FUNC_W-1:0]         func_r, func_nxt;
  logic signed [rcf_pkg::POS_W-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [rcf_pkg::RAD_W-1:0]          r_r, r_nxt;
  logic [rcf_pkg::COLOR_W-1:0]        color_r, color_nxt;
  logic                               rd_ok_r, rd_ok_nxt;
  logic signed [CW-1:0]               x0_r, x0_nxt, xe_r, xe_nxt;
  logic signed [CW-1:0]               y0_r, y0_nxt, ye_r, ye_nxt;
  logic signed [MW-1:0]               dx0_r, dx0_nxt, dx_r, dx_nxt;
  logic signed [MW-1:0]               dy0_r, dy0_nxt, dy_r, dy_nxt;
  logic signed [QW-1:0]               rr_r, rr_nxt, sqx0_r, sqx0_nxt;
  logic signed [QW-1:0]               sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [XW-1:0]                      x_r, x_nxt, xs_r, xs_nxt, xl_r, xl_nxt;
  logic [YW-1:0]                      y_r, y_nxt, yl_r, yl_nxt;
  logic [AW-1:0]                      row_base_r, row_base_nxt;
  logic [AW-1:0]                      clr_r, clr_nxt;
  logic [rcf_pkg::COUNT_W-1:0]        count_r, count_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [rcf_pkg::COLOR_W-1:0]        out_value_r, out_value_nxt;
  logic [rcf_pkg::COUNT_W-1:0]        out_count_r, out_count_nxt;

  logic signed [MW-1:0]               mul_a, mul_b;
  logic signed [rcf_pkg::PROD_W-1:0]  mul_p;

  logic signed [CW-1:0] pxs, pys, rext, wext, hext;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, xlast, ylast;
  logic signed [QW-1:0] dx_q, dy_q;
  logic                 is_rect, disc_hit;

  rcf_mul u_mul (
    .clk (clk),
    .a_i (mul_a),
    .b_i (mul_b),
    .p_r (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rcf_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    r_r        <= r_nxt;
    color_r    <= color_nxt;
    rd_ok_r    <= rd_ok_nxt;
    x0_r       <= x0_nxt;
    xe_r       <= xe_nxt;
    y0_r       <= y0_nxt;
    ye_r       <= ye_nxt;
    dx0_r      <= dx0_nxt;
    dx_r       <= dx_nxt;
    dy0_r      <= dy0_nxt;
    dy_r       <= dy_nxt;
    rr_r       <= rr_nxt;
    sqx0_r     <= sqx0_nxt;
    sqx_r      <= sqx_nxt;
    sqy_r      <= sqy_nxt;
    x_r        <= x_nxt;
    xs_r       <= xs_nxt;
    xl_r       <= xl_nxt;
    y_r        <= y_nxt;
    yl_r       <= yl_nxt;
    row_base_r <= row_base_nxt;
    count_r    <= count_nxt;
    out_value_r <= out_value_nxt;
    out_count_r <= out_count_nxt;
  end

  // Bounding box of the request before clipping, upper bounds exclusive.
  always_comb begin
    pxs     = CW'(in_pos_x);
    pys     = CW'(in_pos_y);
    rext    = CW'(in_radius);
    wext    = CW'(in_width_px);
    hext    = CW'(in_height_px);
    is_rect = (in_func == rcf_pkg::FUNC_RECT);
    lo_x    = is_rect ? pxs : pxs - rext;
    hi_x    = is_rect ? pxs + wext : pxs + rext + ONE_C;
    lo_y    = is_rect ? pys : pys - rext;
    hi_y    = is_rect ? pys + hext : pys + rext + ONE_C;
  end

  assign xlast = xe_r - ONE_C;
  assign ylast = ye_r - ONE_C;
  assign dx_q  = QW'(dx_r);
  assign dy_q  = QW'(dy_r);
  assign disc_hit = (func_r != rcf_pkg::FUNC_CIRCLE) || (sqx_r + sqy_r <= rr_r);

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    r_nxt         = r_r;
    color_nxt     = color_r;
    rd_ok_nxt     = rd_ok_r;
    x0_nxt        = x0_r;
    xe_nxt        = xe_r;
    y0_nxt        = y0_r;
    ye_nxt        = ye_r;
    dx0_nxt       = dx0_r;
    dx_nxt        = dx_r;
    dy0_nxt       = dy0_r;
    dy_nxt        = dy_r;
    rr_nxt        = rr_r;
    sqx0_nxt      = sqx0_r;
    sqx_nxt       = sqx_r;
    sqy_nxt       = sqy_r;
    x_nxt         = x_r;
    xs_nxt        = xs_r;
    xl_nxt        = xl_r;
    y_nxt         = y_r;
    yl_nxt        = yl_r;
    row_base_nxt  = row_base_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    out_count_nxt = out_count_r;
    mul_a         = '0;
    mul_b         = '0;
    mem_we        = 1'b0;
    mem_waddr     = row_base_r + AW'(x_r);
    mem_wdata     = color_r;
    mem_re        = 1'b0;
    mem_raddr     = mul_p[AW-1:0] + AW'($unsigned(px_r));

    unique case (state_r)
      rcf_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ADDR) begin
          state_nxt = rcf_pkg::S_IDLE;
        end
      end
      rcf_pkg::S_IDLE: begin
        if (start) begin
          func_nxt  = in_func;
          px_nxt    = in_pos_x;
          py_nxt    = in_pos_y;
          r_nxt     = in_radius;
          color_nxt = in_pixel_color;
          count_nxt = '0;
          x0_nxt    = (lo_x < 0) ? '0 : lo_x;
          xe_nxt    = (hi_x > W_C) ? W_C : hi_x;
          y0_nxt    = (lo_y < 0) ? '0 : lo_y;
          ye_nxt    = (hi_y > H_C) ? H_C : hi_y;
          rd_ok_nxt = (pxs >= 0) && (pxs < W_C) && (pys >= 0) && (pys < H_C);
          unique case (in_func)
            rcf_pkg::FUNC_RECT, rcf_pkg::FUNC_CIRCLE: state_nxt = rcf_pkg::S_CHECK;
            rcf_pkg::FUNC_READ:                      state_nxt = rcf_pkg::S_RD_MUL;
            default:                                 state_nxt = rcf_pkg::S_FIN;
          endcase
        end
      end
      rcf_pkg::S_CHECK: begin
        dx0_nxt = MW'(x0_r - CW'(px_r));
        dy0_nxt = MW'(y0_r - CW'(py_r));
        xs_nxt  = x0_r[XW-1:0];
        xl_nxt  = xlast[XW-1:0];
        yl_nxt  = ylast[YW-1:0];
        y_nxt   = y0_r[YW-1:0];
        mul_a   = MW'(y0_r);
        mul_b   = STRIDE_M;
        if ((x0_r >= xe_r) || (y0_r >= ye_r)) begin
          state_nxt = rcf_pkg::S_FIN;
        end else begin
          state_nxt = rcf_pkg::S_M_ROW;
        end
      end
      rcf_pkg::S_M_ROW: begin
        row_base_nxt = mul_p[AW-1:0];
        mul_a        = MW'(r_r);
        mul_b        = MW'(r_r);
        state_nxt    = rcf_pkg::S_M_RR;
      end
      rcf_pkg::S_M_RR: begin
        rr_nxt    = QW'(mul_p);
        mul_a     = dx0_r;
        mul_b     = dx0_r;
        state_nxt = rcf_pkg::S_M_DX;
      end
      rcf_pkg::S_M_DX: begin
        sqx0_nxt  = QW'(mul_p);
        sqx_nxt   = QW'(mul_p);
        mul_a     = dy0_r;
        mul_b     = dy0_r;
        state_nxt = rcf_pkg::S_M_DY;
      end
      rcf_pkg::S_M_DY: begin
        sqy_nxt   = QW'(mul_p);
        x_nxt     = xs_r;
        dx_nxt    = dx0_r;
        dy_nxt    = dy0_r;
        state_nxt = rcf_pkg::S_DRAW;
      end
      rcf_pkg::S_DRAW: begin
        mem_we    = disc_hit;
        count_nxt = count_r + rcf_pkg::COUNT_W'(disc_hit);
        if (x_r == xl_r) begin
          if (y_r == yl_r) begin
            state_nxt = rcf_pkg::S_FIN;
          end else begin
            y_nxt        = y_r + YW'(1);
            dy_nxt       = dy_r + MW'(1);
            sqy_nxt      = sqy_r + (dy_q <<< 1) + ONE_Q;
            row_base_nxt = row_base_r + STRIDE_A;
            x_nxt        = xs_r;
            dx_nxt       = dx0_r;
            sqx_nxt      = sqx0_r;
          end
        end else begin
          x_nxt   = x_r + XW'(1);
          dx_nxt  = dx_r + MW'(1);
          sqx_nxt = sqx_r + (dx_q <<< 1) + ONE_Q;
        end
      end
      rcf_pkg::S_FIN: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = '0;
        out_count_nxt = count_r;
        state_nxt     = rcf_pkg::S_IDLE;
      end
      rcf_pkg::S_RD_MUL: begin
        mul_a     = MW'(py_r);
        mul_b     = STRIDE_M;
        state_nxt = rcf_pkg::S_RD_ADDR;
      end
      rcf_pkg::S_RD_ADDR: begin
        mem_re    = rd_ok_r;
        state_nxt = rcf_pkg::S_RD_DATA;
      end
      rcf_pkg::S_RD_DATA: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = rd_ok_r ? mem_rdata : '0;
        out_count_nxt = '0;
        state_nxt     = rcf_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rcf_pkg::S_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != rcf_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_pixel_count = out_count_r;

  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == rcf_pkg::S_DRAW || state_r == rcf_pkg::S_CLEAR))
    else $error("frame store written outside a draw or clearing pass");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == rcf_pkg::S_DRAW) |-> (32'(mem_waddr) < STORE_DEPTH))
    else $error("draw address beyond the frame store");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == rcf_pkg::S_FIN || $past(state_r) == rcf_pkg::S_RD_DATA))
    else $error("result strobe without a finished request");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

endmodule

### hw/rtl/rect_circle_fill_rasterizer.sv
// Rectangle and circle draws pass a check and four multiply states, then walk the clipped
// bounding box one pixel a cycle through the frame store write port to the finish state.
// A draw clipped to nothing leaves the check for finish, an unused command goes there at once;
// a read passes multiply, address and data states. The next request is taken in the cycle the
// result strobe is high; results cannot be stalled. After reset the frame store is cleared one
// word a cycle, SCREEN_H * ROW_STRIDE + SCREEN_W words (123200 by default); busy stays high.
module rect_circle_fill_rasterizer #(
  parameter int SCREEN_W   = rcf_pkg::SCREEN_W_DEF,
  parameter int SCREEN_H   = rcf_pkg::SCREEN_H_DEF,
  parameter int ROW_STRIDE = rcf_pkg::ROW_STRIDE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rcf_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [rcf_pkg::POS_W-1:0]    in_pos_x,
  input  logic signed [rcf_pkg::POS_W-1:0]    in_pos_y,
  input  logic [rcf_pkg::DIM_W-1:0]           in_width_px,
  input  logic [rcf_pkg::DIM_W-1:0]           in_height_px,
  input  logic [rcf_pkg::RAD_W-1:0]           in_radius,
  input  logic [rcf_pkg::COLOR_W-1:0]         in_pixel_color,
  output logic                                out_valid,
  output logic [rcf_pkg::COLOR_W-1:0]         out_read_value,
  output logic [rcf_pkg::COUNT_W-1:0]         out_pixel_count
);

  localparam int STORE_DEPTH = SCREEN_H * ROW_STRIDE + SCREEN_W;
  localparam int AW          = $clog2(STORE_DEPTH);

  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [rcf_pkg::COLOR_W-1:0]  mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [rcf_pkg::COLOR_W-1:0]  mem_rdata;

  rcf_seq #(
    .SCREEN_W    (SCREEN_W),
    .SCREEN_H    (SCREEN_H),
    .ROW_STRIDE  (ROW_STRIDE),
    .STORE_DEPTH (STORE_DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_width_px     (in_width_px),
    .in_height_px    (in_height_px),
    .in_radius       (in_radius),
    .in_pixel_color  (in_pixel_color),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_pixel_count (out_pixel_count),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_re          (mem_re),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  rcf_mem #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_r (mem_rdata)
  );

endmodule
